@@ rtl/c1252u8_pkg.sv @@
// Shared types, constants and the CP1252 code point table for the line splitter.
`timescale 1ns / 1ps

package c1252u8_pkg;

  // Leading indent counter width and its saturation value
  localparam int unsigned IndentBits = 8;
  localparam int unsigned IndentW    = 8;
  localparam logic [IndentW-1:0] IndentCap =
    (IndentBits >= 8) ? 8'hFF : IndentW'((1 << IndentBits) - 1);

  // Work queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Byte codes the front reacts to
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharSp  = 8'h20;

  // CP1252 remap window
  localparam logic [7:0] CpLow  = 8'h80;
  localparam logic [7:0] CpHigh = 8'h9F;

  // Result kind codes
  localparam logic KindText   = 1'b0;
  localparam logic KindMarker = 1'b1;

  // One accepted byte's worth of results: up to three text bytes, then an optional marker
  typedef struct packed {
    logic [1:0]         n_text;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic               mark;
    logic [IndentW-1:0] indent;
  } job_t;

  // Map a byte in 0x80..0x9F to its CP1252 code point
  function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
    logic [15:0] cp;
    unique case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008D;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      default: cp = 16'h0178;
    endcase
    return cp;
  endfunction

endpackage

@@ rtl/cp1252_text_to_utf8_line_splitter.sv @@
// Top level of the CP1252/UTF-8 text line splitter.
`timescale 1ns / 1ps

// Takes raw text bytes, one per transfer on the slave stream (tlast marks the
// last byte of a text unit), and returns a stream of results: UTF-8 text bytes
// (tuser 0) and end-of-line markers (tuser 1) that carry the line's stripped
// leading indent in tdata[15:8]. CR, LF and CR LF each end one line; tlast on
// the master stream marks the final result caused by one input byte. Set
// cfg_wdata_i to 1 for CP1252 transcoding, 0 to pass UTF-8 through; write it
// only while the block is idle. Each input byte gives zero to four results and
// the master stream carries one result per cycle while m_axis_tready is high:
// one for pass-through text, none for leading whitespace, one marker for a line
// end, two or three text bytes for a transcoded byte above 0x7F, and one more
// marker when the byte closes the unit's open line. A two-entry job queue lets
// the input side run ahead while results drain.
module cp1252_text_to_utf8_line_splitter import c1252u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // latin1_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,     // [7:0] in_byte
  input  logic        s_axis_tlast,     // end_of_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,     // [7:0] text_byte, [15:8] line_indent
  output logic        m_axis_tuser,     // [0] item_kind
  output logic        m_axis_tlast      // last_of_run
);

  logic               push;
  job_t               push_job;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  job_t               head_job;
  logic [7:0]         out_byte;
  logic [IndentW-1:0] out_indent;

  c1252u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eou_i    (s_axis_tlast),
    .job_push_o  (push),
    .job_o       (push_job),
    .q_full_i    (q_full)
  );

  c1252u8_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  c1252u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_byte_o   (out_byte),
    .out_indent_o (out_indent),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {8'(out_indent), out_byte};

endmodule

@@ rtl/c1252u8_front.sv @@
// Front end: accepts raw bytes, tracks line state and builds one job per byte.
`timescale 1ns / 1ps

module c1252u8_front import c1252u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eou_i,
  output logic       job_push_o,
  output job_t       job_o,
  input  logic       q_full_i
);

  logic               latin1_q;
  logic               phase_q, phase_d;
  logic [IndentW-1:0] count_q, count_d;
  logic               after_cr_q, after_cr_d;
  logic               open_q, open_d;
  logic               accept;
  logic               swallow, is_term, is_ws;
  logic [15:0]        cp;
  logic [IndentW:0]   sum;
  job_t               job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign swallow = after_cr_q && (in_byte_i == CharLf);
  assign is_term = (in_byte_i == CharCr) || (in_byte_i == CharLf);
  assign is_ws   = phase_q && ((in_byte_i == CharSp) || (in_byte_i == CharTab));

  // Code point: CP1252 window remapped, else the byte itself
  always_comb begin
    if (in_byte_i >= CpLow && in_byte_i <= CpHigh) begin
      cp = cp1252_map(in_byte_i[4:0]);
    end else begin
      cp = {8'h00, in_byte_i};
    end
  end

  // Saturating indent sum
  assign sum = {1'b0, count_q} + ((in_byte_i == CharTab) ? (IndentW+1)'(8) : (IndentW+1)'(1));

  // Classify the byte and build its job and next line state
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    open_d     = open_q;
    after_cr_d = 1'b0;
    job        = '0;
    job.indent = count_q;
    if (!swallow) begin
      if (is_term) begin
        job.mark   = 1'b1;
        job.indent = count_q;
        phase_d    = 1'b1;
        count_d    = '0;
        open_d     = 1'b0;
        after_cr_d = (in_byte_i == CharCr);
      end else if (is_ws) begin
        count_d = (sum > {1'b0, IndentCap}) ? IndentCap : sum[IndentW-1:0];
        open_d  = 1'b1;
      end else begin
        phase_d = 1'b0;
        open_d  = 1'b1;
        if (!latin1_q) begin
          job.n_text = 2'd1;
          job.b0     = in_byte_i;
        end else if (cp < 16'h0080) begin
          job.n_text = 2'd1;
          job.b0     = cp[7:0];
        end else if (cp < 16'h0800) begin
          job.n_text = 2'd2;
          job.b0     = {3'b110, cp[10:6]};
          job.b1     = {2'b10, cp[5:0]};
        end else begin
          job.n_text = 2'd3;
          job.b0     = {4'b1110, cp[15:12]};
          job.b1     = {2'b10, cp[11:6]};
          job.b2     = {2'b10, cp[5:0]};
        end
      end
    end
    // Close an open line at end of unit and drop all line state
    if (in_eou_i) begin
      if (open_d) begin
        job.mark   = 1'b1;
        job.indent = count_d;
      end
      phase_d    = 1'b1;
      count_d    = '0;
      open_d     = 1'b0;
      after_cr_d = 1'b0;
    end
  end

  assign job_o      = job;
  assign job_push_o = accept && ((job.n_text != 2'd0) || job.mark);

  // Line state and mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latin1_q   <= 1'b0;
      phase_q    <= 1'b1;
      count_q    <= '0;
      after_cr_q <= 1'b0;
      open_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        latin1_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q    <= phase_d;
        count_q    <= count_d;
        after_cr_q <= after_cr_d;
        open_q     <= open_d;
      end
    end
  end

endmodule

@@ rtl/c1252u8_queue.sv @@
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module c1252u8_queue import c1252u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_job_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("job popped from empty queue");

endmodule

@@ rtl/c1252u8_back.sv @@
// Back end: walks each queued job and sends its results through an output register.
`timescale 1ns / 1ps

module c1252u8_back import c1252u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  job_t        head_job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [IndentW-1:0] out_indent_o,
  output logic        out_last_o
);

  logic               valid_q, valid_d;
  logic [1:0]         idx_q, idx_d;
  logic               kind_q;
  logic [7:0]         byte_q;
  logic [IndentW-1:0] indent_q;
  logic               last_q;
  logic               load;
  logic [2:0]         total;
  logic               item_last;
  logic               item_kind;
  logic [7:0]         item_byte;
  logic [IndentW-1:0] item_indent;

  assign total     = {1'b0, head_job_i.n_text} + {2'b00, head_job_i.mark};
  assign item_last = ({1'b0, idx_q} == (total - 3'd1));
  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o     = load && item_last;

  // Pick the current item: text bytes first, then the marker
  always_comb begin
    item_kind   = KindMarker;
    item_byte   = '0;
    item_indent = head_job_i.indent;
    if (idx_q < head_job_i.n_text) begin
      item_kind   = KindText;
      item_indent = '0;
      unique case (idx_q)
        2'd0:    item_byte = head_job_i.b0;
        2'd1:    item_byte = head_job_i.b1;
        default: item_byte = head_job_i.b2;
      endcase
    end
  end

  // Step through the job and hold the output while stalled
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = item_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= item_kind;
      byte_q   <= item_byte;
      indent_q <= item_indent;
      last_q   <= item_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign out_byte_o   = byte_q;
  assign out_indent_o = indent_q;
  assign out_last_o   = last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ({1'b0, idx_q} < total))
    else $error("item index beyond job length");

  a_marker_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindMarker) |-> (byte_q == '0))
    else $error("marker carries a text byte");

  a_text_no_indent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindText) |-> (indent_q == '0))
    else $error("text byte carries an indent");

  a_marker_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindMarker) |-> last_q)
    else $error("marker is not the last result of its byte");

endmodule
